// ----- rtl/alsf_pkg.sv -----
// Shared types and constants for the least-squares affine fit block.
// No dependencies; imported by rtl/affine_least_squares_fit.sv.
package alsf_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int CNT_W          = 11;
    localparam int MIN_PAIRS      = 3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_SING = 2'd2;
    localparam logic [1:0] ST_OVER = 2'd3;

    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [23:0] src_x;
        logic signed [23:0] src_y;
        logic signed [23:0] dst_x;
        logic signed [23:0] dst_y;
        logic               last_point;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] coef_a0;
        logic signed [63:0] coef_a1;
        logic signed [63:0] coef_a2;
        logic signed [63:0] coef_b0;
        logic signed [63:0] coef_b1;
        logic signed [63:0] coef_b2;
        logic [CNT_W-1:0]   points_used;
    } out_t;

endpackage

// ----- rtl/affine_least_squares_fit.sv -----
// Least-squares affine fit: normal-equation sums and a Gauss-Jordan solve.
// Depends on rtl/alsf_pkg.sv (request types, status codes, constants).
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  input    | in_valid / in_ready    | in_data  (alsf_pkg::in_t)
//  output   | out_valid / out_ready  | out_data (alsf_pkg::out_t)
//  config   | cfg_wr_en              | cfg_wr_data (singular floor)
//
// A point request is accepted, then steps through the shared 32x32 multiplier for the
// seven products. A request marked last then solves: 11 means and up to 9 pivot-row
// divisions per axis in the bit-serial divider. in_ready is high only when idle.
// A result waits in the output register; the next point request is accepted while
// it waits, and only a new solve result stalls on it. Reset is asynchronous, active
// low, clears the sums and sets the floor to 1.
module affine_least_squares_fit #(
    parameter int MAX_POINTS = alsf_pkg::MAX_POINTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  alsf_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output alsf_pkg::out_t out_data,
    input  logic           cfg_wr_en,
    input  logic [31:0]    cfg_wr_data
);
    import alsf_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ACC    = 5'd1;
    localparam logic [4:0] S_DECIDE = 5'd2;
    localparam logic [4:0] S_MEAN   = 5'd3;
    localparam logic [4:0] S_MEAN_W = 5'd4;
    localparam logic [4:0] S_LOAD   = 5'd5;
    localparam logic [4:0] S_PIV    = 5'd6;
    localparam logic [4:0] S_PCHK   = 5'd7;
    localparam logic [4:0] S_SWAP   = 5'd8;
    localparam logic [4:0] S_NORM_P = 5'd9;
    localparam logic [4:0] S_NORM_S = 5'd10;
    localparam logic [4:0] S_NORM_W = 5'd11;
    localparam logic [4:0] S_ELIM_F = 5'd12;
    localparam logic [4:0] S_ELIM_M = 5'd13;
    localparam logic [4:0] S_ELIM_S = 5'd14;
    localparam logic [4:0] S_SOL    = 5'd15;
    localparam logic [4:0] S_EMIT   = 5'd16;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] sat_sign(input logic [63:0] m, input logic neg);
        logic [63:0] mm;
        mm = (m > SAT_POS) ? SAT_POS : m;
        sat_sign = neg ? (64'd0 - mm) : mm;
    endfunction

    // control
    logic [4:0]       state_reg;
    logic [3:0]       k_reg;
    logic [2:0]       ph_reg;
    logic [1:0]       col_reg, row_reg, j_reg, best_reg;
    logic             axis_reg;
    logic [1:0]       status_reg;
    logic [CNT_W-1:0] pair_count_reg;
    logic             overflow_reg;
    logic signed [39:0] fs_reg [4];
    logic signed [57:0] ss_reg [7];
    logic [31:0]      floor_reg;
    logic             out_valid_reg;
    logic             dv_busy_reg, dv_fin_reg, dv_done_reg;
    logic [6:0]       dv_cnt_reg;

    // datapath
    logic signed [23:0] px_reg, py_reg, pdx_reg, pdy_reg;
    logic             last_reg, add_reg, mneg_reg;
    logic [63:0]      mul_p_reg;
    logic [127:0]     acc_reg;
    logic [63:0]      mean_reg [11];
    logic [63:0]      mat_reg [12];
    logic [63:0]      tmp_reg, f_mag_reg, y_mag_reg, piv_reg, bestv_reg;
    logic             fneg_reg, yneg_reg;
    logic [63:0]      coef_reg [6];
    out_t             out_reg;
    logic [127:0]     dv_num_reg;
    logic [63:0]      dv_rem_reg, dv_q_reg, dv_d_reg, dv_res_reg;
    logic             dv_over_reg, dv_round_reg, dv_neg_reg;

    logic             in_fire;
    logic [3:0]       rd_addr;
    logic [63:0]      m_rd, m_rd_mag;
    logic [23:0]      xm, ym, dxm, dym;
    logic [31:0]      mul_a, mul_b;
    logic             mul_neg;
    logic [1:0]       pp_i, acc_i;
    logic [6:0]       acc_sh;
    logic [63:0]      prod_mag, prod_val, sub_val;
    logic signed [64:0] diff;
    logic signed [63:0] msum;
    logic [4:0]       mshift;
    logic             dv_start;
    logic [127:0]     dv_num_in;
    logic [63:0]      dv_d_in;
    logic             dv_round_in, dv_neg_in;
    logic [63:0]      dv_sh, dv_rem_new;
    logic             dv_ge, dv_up;
    logic [63:0]      dv_qf, dv_res_in;
    logic             emit_ok, out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // single read port on the elimination matrix
    always_comb
    begin
        rd_addr = 4'd0;
        unique case (state_reg)
            S_PIV:    rd_addr = {row_reg, col_reg};
            S_SWAP:   rd_addr = (ph_reg == 3'd1) ? {best_reg, j_reg} : {col_reg, j_reg};
            S_NORM_P: rd_addr = {col_reg, col_reg};
            S_NORM_S: rd_addr = {col_reg, j_reg};
            S_ELIM_F: rd_addr = {row_reg, col_reg};
            S_ELIM_M: rd_addr = {col_reg, j_reg};
            S_ELIM_S: rd_addr = {row_reg, j_reg};
            default:  rd_addr = 4'd0;
        endcase
    end
    assign m_rd     = mat_reg[rd_addr];
    assign m_rd_mag = mag64(m_rd);

    assign xm  = px_reg[23]  ? (24'd0 - px_reg)  : px_reg;
    assign ym  = py_reg[23]  ? (24'd0 - py_reg)  : py_reg;
    assign dxm = pdx_reg[23] ? (24'd0 - pdx_reg) : pdx_reg;
    assign dym = pdy_reg[23] ? (24'd0 - pdy_reg) : pdy_reg;

    assign pp_i  = 2'(ph_reg - 3'd1);
    assign acc_i = 2'(ph_reg - 3'd2);
    always_comb
    begin
        case (acc_i)
            2'd0:    acc_sh = 7'd0;
            2'd3:    acc_sh = 7'd64;
            default: acc_sh = 7'd32;
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        mul_neg = 1'b0;
        if (state_reg == S_ACC)
        begin
            case (k_reg)
                4'd0:    begin mul_a = {8'd0, xm}; mul_b = {8'd0, xm};  mul_neg = 1'b0; end
                4'd1:    begin mul_a = {8'd0, xm}; mul_b = {8'd0, ym};
                               mul_neg = px_reg[23] ^ py_reg[23]; end
                4'd2:    begin mul_a = {8'd0, ym}; mul_b = {8'd0, ym};  mul_neg = 1'b0; end
                4'd3:    begin mul_a = {8'd0, xm}; mul_b = {8'd0, dxm};
                               mul_neg = px_reg[23] ^ pdx_reg[23]; end
                4'd4:    begin mul_a = {8'd0, ym}; mul_b = {8'd0, dxm};
                               mul_neg = py_reg[23] ^ pdx_reg[23]; end
                4'd5:    begin mul_a = {8'd0, xm}; mul_b = {8'd0, dym};
                               mul_neg = px_reg[23] ^ pdy_reg[23]; end
                4'd6:    begin mul_a = {8'd0, ym}; mul_b = {8'd0, dym};
                               mul_neg = py_reg[23] ^ pdy_reg[23]; end
                default: begin mul_a = 32'd0; mul_b = 32'd0; mul_neg = 1'b0; end
            endcase
        end
        else if (state_reg == S_ELIM_M)
        begin
            mul_a = pp_i[1] ? f_mag_reg[63:32] : f_mag_reg[31:0];
            mul_b = pp_i[0] ? y_mag_reg[63:32] : y_mag_reg[31:0];
        end
    end

    // rounded Q31.32 product and saturating subtract
    assign prod_mag = (|acc_reg[127:96]) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_reg[95:32];
    assign prod_val = sat_sign(prod_mag, fneg_reg ^ yneg_reg);
    assign diff     = $signed({m_rd[63], m_rd}) - $signed({prod_val[63], prod_val});
    always_comb
    begin
        if (diff > $signed({1'b0, SAT_POS}))
            sub_val = SAT_POS;
        else if (diff < -$signed({1'b0, SAT_POS}))
            sub_val = 64'd0 - SAT_POS;
        else
            sub_val = diff[63:0];
    end

    // mean source select
    always_comb
    begin
        case (k_reg)
            4'd0:    msum = 64'(fs_reg[0]);
            4'd1:    msum = 64'(fs_reg[1]);
            4'd2:    msum = 64'(ss_reg[0]);
            4'd3:    msum = 64'(ss_reg[1]);
            4'd4:    msum = 64'(ss_reg[2]);
            4'd5:    msum = 64'(fs_reg[2]);
            4'd6:    msum = 64'(ss_reg[3]);
            4'd7:    msum = 64'(ss_reg[4]);
            4'd8:    msum = 64'(fs_reg[3]);
            4'd9:    msum = 64'(ss_reg[5]);
            default: msum = 64'(ss_reg[6]);
        endcase
        case (k_reg)
            4'd0, 4'd1, 4'd5, 4'd8: mshift = 5'd24;
            default:                mshift = 5'd16;
        endcase
    end

    // divider launch
    always_comb
    begin
        dv_start    = 1'b0;
        dv_num_in   = 128'd0;
        dv_d_in     = 64'd0;
        dv_round_in = 1'b0;
        dv_neg_in   = 1'b0;
        if (state_reg == S_MEAN)
        begin
            dv_start    = 1'b1;
            dv_num_in   = ({64'd0, mag64(msum)} << mshift) + {118'd0, pair_count_reg[10:1]};
            dv_d_in     = {53'd0, pair_count_reg};
            dv_neg_in   = msum[63];
        end
        else if (state_reg == S_NORM_S)
        begin
            dv_start    = 1'b1;
            dv_num_in   = {32'd0, m_rd_mag, 32'd0};
            dv_d_in     = mag64(piv_reg);
            dv_round_in = 1'b1;
            dv_neg_in   = m_rd[63] ^ piv_reg[63];
        end
    end

    // one restoring step per cycle, then round
    assign dv_sh      = {dv_rem_reg[62:0], dv_num_reg[127]};
    assign dv_ge      = dv_rem_reg[63] || (dv_sh >= dv_d_reg);
    assign dv_rem_new = dv_ge ? (dv_sh - dv_d_reg) : dv_sh;
    assign dv_up      = dv_round_reg && ({dv_rem_reg, 1'b0} >= {1'b0, dv_d_reg});
    assign dv_qf      = dv_q_reg + {63'd0, dv_up};
    assign dv_res_in  = sat_sign((dv_over_reg || (dv_up && (&dv_q_reg)))
                                 ? 64'hFFFF_FFFF_FFFF_FFFF : dv_qf, dv_neg_reg);

    assign emit_ok = (state_reg == S_EMIT) && out_free;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            ph_reg         <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            j_reg          <= '0;
            best_reg       <= '0;
            axis_reg       <= 1'b0;
            status_reg     <= ST_OK;
            pair_count_reg <= '0;
            overflow_reg   <= 1'b0;
            for (int i = 0; i < 4; i++) fs_reg[i] <= '0;
            for (int i = 0; i < 7; i++) ss_reg[i] <= '0;
            floor_reg      <= 32'd1;
            out_valid_reg  <= 1'b0;
            dv_busy_reg    <= 1'b0;
            dv_fin_reg     <= 1'b0;
            dv_done_reg    <= 1'b0;
            dv_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                floor_reg <= cfg_wr_data;

            if (emit_ok)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            dv_done_reg <= dv_fin_reg;
            dv_fin_reg  <= 1'b0;
            if (dv_start)
            begin
                dv_busy_reg <= 1'b1;
                dv_cnt_reg  <= '0;
            end
            else if (dv_busy_reg)
            begin
                dv_cnt_reg <= dv_cnt_reg + 7'd1;
                if (&dv_cnt_reg)
                begin
                    dv_busy_reg <= 1'b0;
                    dv_fin_reg  <= 1'b1;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (pair_count_reg < CNT_W'(MAX_POINTS))
                        begin
                            fs_reg[0] <= fs_reg[0] + 40'(in_data.src_x);
                            fs_reg[1] <= fs_reg[1] + 40'(in_data.src_y);
                            fs_reg[2] <= fs_reg[2] + 40'(in_data.dst_x);
                            fs_reg[3] <= fs_reg[3] + 40'(in_data.dst_y);
                            pair_count_reg <= pair_count_reg + 1'b1;
                        end
                        else
                            overflow_reg <= 1'b1;
                        k_reg     <= '0;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (k_reg != 4'd0 && add_reg)
                        ss_reg[3'(k_reg - 4'd1)] <= ss_reg[3'(k_reg - 4'd1)] +
                            (mneg_reg ? (58'd0 - {10'd0, mul_p_reg[47:0]})
                                      : {10'd0, mul_p_reg[47:0]});
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == 4'd7)
                        state_reg <= last_reg ? S_DECIDE : S_IDLE;
                end
                S_DECIDE:
                begin
                    k_reg    <= '0;
                    axis_reg <= 1'b0;
                    if (overflow_reg)
                    begin
                        status_reg <= ST_OVER;
                        state_reg  <= S_EMIT;
                    end
                    else if (pair_count_reg < CNT_W'(MIN_PAIRS))
                    begin
                        status_reg <= ST_FEW;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        state_reg  <= S_MEAN;
                    end
                end
                S_MEAN:
                    state_reg <= S_MEAN_W;
                S_MEAN_W:
                begin
                    if (dv_done_reg)
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= (k_reg == 4'd10) ? S_LOAD : S_MEAN;
                    end
                end
                S_LOAD:
                begin
                    col_reg   <= 2'd0;
                    row_reg   <= 2'd0;
                    state_reg <= S_PIV;
                end
                S_PIV:
                begin
                    if (row_reg == col_reg || m_rd_mag > bestv_reg)
                        best_reg <= row_reg;
                    if (row_reg == 2'd2)
                        state_reg <= S_PCHK;
                    else
                        row_reg <= row_reg + 2'd1;
                end
                S_PCHK:
                begin
                    j_reg  <= 2'd0;
                    ph_reg <= 3'd0;
                    if (bestv_reg == 64'd0 || bestv_reg < {32'd0, floor_reg})
                    begin
                        status_reg <= ST_SING;
                        state_reg  <= S_EMIT;
                    end
                    else
                        state_reg <= (best_reg != col_reg) ? S_SWAP : S_NORM_P;
                end
                S_SWAP:
                begin
                    if (ph_reg == 3'd2)
                    begin
                        ph_reg <= 3'd0;
                        j_reg  <= j_reg + 2'd1;
                        if (j_reg == 2'd3)
                            state_reg <= S_NORM_P;
                    end
                    else
                        ph_reg <= ph_reg + 3'd1;
                end
                S_NORM_P:
                begin
                    j_reg     <= col_reg;
                    state_reg <= S_NORM_S;
                end
                S_NORM_S:
                    state_reg <= S_NORM_W;
                S_NORM_W:
                begin
                    if (dv_done_reg)
                    begin
                        if (j_reg == 2'd3)
                        begin
                            row_reg   <= 2'd0;
                            state_reg <= S_ELIM_F;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= S_NORM_S;
                        end
                    end
                end
                S_ELIM_F:
                begin
                    if (row_reg == col_reg)
                    begin
                        if (row_reg == 2'd2)
                        begin
                            if (col_reg == 2'd2)
                                state_reg <= S_SOL;
                            else
                            begin
                                col_reg   <= col_reg + 2'd1;
                                row_reg   <= col_reg + 2'd1;
                                state_reg <= S_PIV;
                            end
                        end
                        else
                            row_reg <= row_reg + 2'd1;
                    end
                    else
                    begin
                        j_reg     <= col_reg;
                        ph_reg    <= 3'd0;
                        state_reg <= S_ELIM_M;
                    end
                end
                S_ELIM_M:
                begin
                    ph_reg <= ph_reg + 3'd1;
                    if (ph_reg == 3'd5)
                        state_reg <= S_ELIM_S;
                end
                S_ELIM_S:
                begin
                    ph_reg <= 3'd0;
                    if (j_reg == 2'd3)
                    begin
                        if (row_reg == 2'd2)
                        begin
                            if (col_reg == 2'd2)
                                state_reg <= S_SOL;
                            else
                            begin
                                col_reg   <= col_reg + 2'd1;
                                row_reg   <= col_reg + 2'd1;
                                state_reg <= S_PIV;
                            end
                        end
                        else
                        begin
                            row_reg   <= row_reg + 2'd1;
                            state_reg <= S_ELIM_F;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 2'd1;
                        state_reg <= S_ELIM_M;
                    end
                end
                S_SOL:
                begin
                    if (axis_reg)
                        state_reg <= S_EMIT;
                    else
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_LOAD;
                    end
                end
                S_EMIT:
                begin
                    // hold until the output register is free, then drop the sums
                    if (out_free)
                    begin
                        pair_count_reg <= '0;
                        overflow_reg   <= 1'b0;
                        for (int i = 0; i < 4; i++) fs_reg[i] <= '0;
                        for (int i = 0; i < 7; i++) ss_reg[i] <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mul_p_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        mneg_reg  <= mul_neg;

        if (in_fire)
        begin
            px_reg   <= in_data.src_x;
            py_reg   <= in_data.src_y;
            pdx_reg  <= in_data.dst_x;
            pdy_reg  <= in_data.dst_y;
            last_reg <= in_data.last_point;
            add_reg  <= (pair_count_reg < CNT_W'(MAX_POINTS));
        end

        if (dv_start)
        begin
            dv_num_reg   <= dv_num_in;
            dv_d_reg     <= dv_d_in;
            dv_round_reg <= dv_round_in;
            dv_neg_reg   <= dv_neg_in;
            dv_rem_reg   <= 64'd0;
            dv_q_reg     <= 64'd0;
            dv_over_reg  <= 1'b0;
        end
        else if (dv_busy_reg)
        begin
            dv_num_reg  <= {dv_num_reg[126:0], 1'b0};
            dv_rem_reg  <= dv_rem_new;
            dv_q_reg    <= {dv_q_reg[62:0], dv_ge};
            dv_over_reg <= dv_over_reg | dv_q_reg[63];
        end
        if (dv_fin_reg)
            dv_res_reg <= dv_res_in;

        case (state_reg)
            S_MEAN_W:
                if (dv_done_reg)
                    mean_reg[k_reg] <= dv_res_reg;
            S_LOAD:
            begin
                mat_reg[0]  <= ONE_Q32;
                mat_reg[1]  <= mean_reg[0];
                mat_reg[2]  <= mean_reg[1];
                mat_reg[3]  <= axis_reg ? mean_reg[8] : mean_reg[5];
                mat_reg[4]  <= mean_reg[0];
                mat_reg[5]  <= mean_reg[2];
                mat_reg[6]  <= mean_reg[3];
                mat_reg[7]  <= axis_reg ? mean_reg[9] : mean_reg[6];
                mat_reg[8]  <= mean_reg[1];
                mat_reg[9]  <= mean_reg[3];
                mat_reg[10] <= mean_reg[4];
                mat_reg[11] <= axis_reg ? mean_reg[10] : mean_reg[7];
            end
            S_PIV:
                if (row_reg == col_reg || m_rd_mag > bestv_reg)
                    bestv_reg <= m_rd_mag;
            S_SWAP:
            begin
                if (ph_reg == 3'd0)
                    tmp_reg <= m_rd;
                else if (ph_reg == 3'd1)
                    mat_reg[{col_reg, j_reg}] <= m_rd;
                else
                    mat_reg[{best_reg, j_reg}] <= tmp_reg;
            end
            S_NORM_P:
                piv_reg <= m_rd;
            S_NORM_W:
                if (dv_done_reg)
                    mat_reg[{col_reg, j_reg}] <= dv_res_reg;
            S_ELIM_F:
            begin
                f_mag_reg <= m_rd_mag;
                fneg_reg  <= m_rd[63];
            end
            S_ELIM_M:
            begin
                if (ph_reg == 3'd0)
                begin
                    y_mag_reg <= m_rd_mag;
                    yneg_reg  <= m_rd[63];
                    acc_reg   <= 128'h8000_0000;
                end
                else if (ph_reg >= 3'd2)
                    acc_reg <= acc_reg + ({64'd0, mul_p_reg} << acc_sh);
            end
            S_ELIM_S:
                mat_reg[{row_reg, j_reg}] <= sub_val;
            S_SOL:
            begin
                if (axis_reg)
                begin
                    coef_reg[3] <= mat_reg[3];
                    coef_reg[4] <= mat_reg[7];
                    coef_reg[5] <= mat_reg[11];
                end
                else
                begin
                    coef_reg[0] <= mat_reg[3];
                    coef_reg[1] <= mat_reg[7];
                    coef_reg[2] <= mat_reg[11];
                end
            end
            default:
                ;
        endcase

        if (emit_ok)
        begin
            out_reg.status      <= status_reg;
            out_reg.coef_a0     <= (status_reg == ST_OK) ? coef_reg[0] : 64'd0;
            out_reg.coef_a1     <= (status_reg == ST_OK) ? coef_reg[1] : 64'd0;
            out_reg.coef_a2     <= (status_reg == ST_OK) ? coef_reg[2] : 64'd0;
            out_reg.coef_b0     <= (status_reg == ST_OK) ? coef_reg[3] : 64'd0;
            out_reg.coef_b1     <= (status_reg == ST_OK) ? coef_reg[4] : 64'd0;
            out_reg.coef_b2     <= (status_reg == ST_OK) ? coef_reg[5] : 64'd0;
            out_reg.points_used <= pair_count_reg;
        end
    end

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
            out_data.coef_a0 == 64'd0 && out_data.coef_a1 == 64'd0 &&
            out_data.coef_a2 == 64'd0 && out_data.coef_b0 == 64'd0 &&
            out_data.coef_b1 == 64'd0 && out_data.coef_b2 == 64'd0)
        else $error("failed fit carries nonzero coefficients");

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OK |->
            out_data.points_used >= CNT_W'(MIN_PAIRS) &&
            out_data.points_used <= CNT_W'(MAX_POINTS))
        else $error("ok result with out-of-range point count");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dv_start |-> !dv_busy_reg && !dv_fin_reg)
        else $error("divider restarted while busy");

    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !dv_busy_reg)
        else $error("input ready while a division runs");

endmodule

// ----- tb/affine_least_squares_fit_test.sv -----
// Testbench for affine_least_squares_fit: random and directed point sets, with a
// fixed-point fit predictor and an in-order result check. Depends on rtl/alsf_pkg.sv.
`timescale 1ns / 100ps
module affine_least_squares_fit_test;
    import alsf_pkg::*;

    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    affine_least_squares_fit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    in_t   point_q[$];
    out_t  fit_q[$];
    int    errors;
    bit    calm;
    bit    in_taken;

    // predictor state
    logic [31:0] floor_q;
    int          pairs;
    bit          overflowed;
    longint      sum1[4];
    longint      sum2[7];
    longint      mat[12];

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint with_sign(logic [63:0] m, bit neg);
        if (m > MAG_MAX)
            m = MAG_MAX;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint mean_of(longint s, int sh, int n);
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        m = mag(s);
        q = m / n;
        r = m % n;
        return with_sign((q << sh) + (((r << sh) + n / 2) / n), s < 0);
    endfunction

    function automatic longint mul_fix(longint a, longint b);
        logic [127:0] p;
        p = {64'b0, mag(a)} * {64'b0, mag(b)} + 128'h8000_0000;
        if (p[127:96] != 0)
            return with_sign('1, (a < 0) != (b < 0));
        return with_sign(p[95:32], (a < 0) != (b < 0));
    endfunction

    function automatic longint div_fix(longint a, longint d);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] nd;
        num = {32'b0, mag(a), 32'b0};
        nd = {64'b0, mag(d)};
        q = num / nd;
        r = num % nd;
        if (r >= nd - r)
            q = q + 1;
        return with_sign(q[127:64] != 0 ? '1 : q[63:0], (a < 0) != (d < 0));
    endfunction

    function automatic longint sub_clamp(longint a, longint b);
        logic signed [64:0] d;
        d = 65'(a) - 65'(b);
        if (d > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            return longint'(MAG_MAX);
        if (d < -65'sh0_7FFF_FFFF_FFFF_FFFF)
            return -longint'(MAG_MAX);
        return longint'(d);
    endfunction

    // Gauss-Jordan on mat; returns 0 on a singular pivot
    function automatic bit eliminate(output longint sol[3]);
        int          best;
        logic [63:0] bestv;
        logic [63:0] v;
        longint      t;
        longint      piv;
        longint      f;
        for (int c = 0; c < 3; c++)
        begin
            best = c;
            bestv = mag(mat[c * 4 + c]);
            for (int r = c + 1; r < 3; r++)
            begin
                v = mag(mat[r * 4 + c]);
                if (v > bestv)
                begin
                    bestv = v;
                    best = r;
                end
            end
            if (bestv == 0 || bestv < {32'b0, floor_q})
                return 1'b0;
            if (best != c)
                for (int j = 0; j < 4; j++)
                begin
                    t = mat[c * 4 + j];
                    mat[c * 4 + j] = mat[best * 4 + j];
                    mat[best * 4 + j] = t;
                end
            piv = mat[c * 4 + c];
            for (int j = c; j < 4; j++)
                mat[c * 4 + j] = div_fix(mat[c * 4 + j], piv);
            for (int r = 0; r < 3; r++)
            begin
                if (r == c)
                    continue;
                f = mat[r * 4 + c];
                for (int j = c; j < 4; j++)
                    mat[r * 4 + j] = sub_clamp(mat[r * 4 + j], mul_fix(f, mat[c * 4 + j]));
            end
        end
        for (int j = 0; j < 3; j++)
            sol[j] = mat[j * 4 + 3];
        return 1'b1;
    endfunction

    function automatic void clear_sums();
        pairs = 0;
        overflowed = 1'b0;
        foreach (sum1[i]) sum1[i] = 0;
        foreach (sum2[i]) sum2[i] = 0;
    endfunction

    // accumulate one pair; on the last pair of a set queue the expected fit
    function automatic void fit_point(in_t p);
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint coef[6];
        longint sol[3];
        longint base[9];
        longint rhs[6];
        logic [1:0] st;
        out_t  e;
        x = p.src_x;
        y = p.src_y;
        dx = p.dst_x;
        dy = p.dst_y;
        if (pairs < MAX_POINTS_DEF)
        begin
            sum1[0] += x;      sum1[1] += y;      sum1[2] += dx;     sum1[3] += dy;
            sum2[0] += x * x;  sum2[1] += x * y;  sum2[2] += y * y;
            sum2[3] += x * dx; sum2[4] += y * dx; sum2[5] += x * dy; sum2[6] += y * dy;
            pairs++;
        end
        else
            overflowed = 1'b1;
        if (!p.last_point)
            return;
        foreach (coef[i]) coef[i] = 0;
        st = ST_OK;
        if (overflowed)
            st = ST_OVER;
        else if (pairs < MIN_PAIRS)
            st = ST_FEW;
        else
        begin
            base[0] = longint'(ONE_Q32);
            base[1] = mean_of(sum1[0], 24, pairs);
            base[2] = mean_of(sum1[1], 24, pairs);
            base[3] = base[1];
            base[4] = mean_of(sum2[0], 16, pairs);
            base[5] = mean_of(sum2[1], 16, pairs);
            base[6] = base[2];
            base[7] = base[5];
            base[8] = mean_of(sum2[2], 16, pairs);
            rhs[0] = mean_of(sum1[2], 24, pairs);
            rhs[1] = mean_of(sum2[3], 16, pairs);
            rhs[2] = mean_of(sum2[4], 16, pairs);
            rhs[3] = mean_of(sum1[3], 24, pairs);
            rhs[4] = mean_of(sum2[5], 16, pairs);
            rhs[5] = mean_of(sum2[6], 16, pairs);
            for (int ax = 0; ax < 2 && st == ST_OK; ax++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                        mat[r * 4 + c] = base[r * 3 + c];
                    mat[r * 4 + 3] = rhs[ax * 3 + r];
                end
                if (eliminate(sol))
                    for (int k = 0; k < 3; k++)
                        coef[ax * 3 + k] = sol[k];
                else
                    st = ST_SING;
            end
            if (st != ST_OK)
                foreach (coef[i]) coef[i] = 0;
        end
        e.status = st;
        e.coef_a0 = coef[0];
        e.coef_a1 = coef[1];
        e.coef_a2 = coef[2];
        e.coef_b0 = coef[3];
        e.coef_b1 = coef[4];
        e.coef_b2 = coef[5];
        e.points_used = pairs[CNT_W-1:0];
        fit_q.push_back(e);
        clear_sums();
    endfunction

    task automatic check_field(string nm, logic [63:0] e, logic [63:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, nm, e, a);
            errors++;
        end
    endtask

    // driver: present the next request at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (point_q.size() != 0 && (calm || $urandom_range(99) >= 33))
                begin
                    in_valid <= 1'b1;
                    in_data <= point_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= calm || $urandom_range(99) >= 33;
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        out_t e;
        in_taken <= in_valid && in_ready;
        if (cfg_wr_en)
            floor_q = cfg_wr_data;
        if (rst_n && in_valid && in_ready)
            fit_point(in_data);
        if (rst_n && out_valid && out_ready)
        begin
            if (fit_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $realtime, out_data);
                errors++;
            end
            else
            begin
                e = fit_q.pop_front();
                check_field("status", 64'(e.status), 64'(out_data.status));
                check_field("coef_a0", e.coef_a0, out_data.coef_a0);
                check_field("coef_a1", e.coef_a1, out_data.coef_a1);
                check_field("coef_a2", e.coef_a2, out_data.coef_a2);
                check_field("coef_b0", e.coef_b0, out_data.coef_b0);
                check_field("coef_b1", e.coef_b1, out_data.coef_b1);
                check_field("coef_b2", e.coef_b2, out_data.coef_b2);
                check_field("points_used", 64'(e.points_used), 64'(out_data.points_used));
            end
        end
    end

    task automatic add_point(int x, int y, int dx, int dy, bit last);
        in_t p;
        p.src_x = x[23:0];
        p.src_y = y[23:0];
        p.dst_x = dx[23:0];
        p.dst_y = dy[23:0];
        p.last_point = last;
        point_q.push_back(p);
    endtask

    // kinds: 0 full-range noise, 1 near-affine small coordinates, 2 collinear
    task automatic add_set(int n, int kind);
        int x;
        int y;
        int a;
        int b;
        int off;
        a = $urandom_range(7) - 3;
        b = $urandom_range(7) - 3;
        off = $urandom_range(65535) - 32768;
        for (int i = 0; i < n; i++)
        begin
            if (kind == 0)
                add_point($urandom, $urandom, $urandom, $urandom, i == n - 1);
            else
            begin
                x = $urandom_range(131071) - 65536;
                y = (kind == 2) ? x * b / 2 + off : $urandom_range(131071) - 65536;
                add_point(x, y, a * x + y / 2 + off + $urandom_range(15),
                          x / 2 - b * y - off + $urandom_range(15), i == n - 1);
            end
        end
    endtask

    task automatic drain();
        while (point_q.size() != 0 || in_valid || fit_q.size() != 0)
            @(posedge clk);
        // a request with no result may still be in flight
        repeat (50) @(posedge clk);
    endtask

    task automatic set_floor(logic [31:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_sets(int items);
        int n;
        int k;
        while (items > 0)
        begin
            k = $urandom_range(9);
            n = (k == 0) ? $urandom_range(2) + 1 : $urandom_range(12) + 3;
            add_set(n, k < 3 ? 0 : (k == 9 ? 2 : 1));
            items -= n;
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        errors = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_taken = 1'b0;
        floor_q = 32'd1;
        clear_sums();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: short sets, extremes, exact and degenerate fits
        add_point(8388607, 8388607, 8388607, 8388607, 1'b1);
        add_point(-8388608, -8388608, -8388608, -8388608, 1'b0);
        add_point(8388607, -8388608, 0, 8388607, 1'b1);
        add_point(0, 0, 100, 200, 1'b0);
        add_point(256, 0, 612, 200, 1'b0);
        add_point(0, 256, 100, 968, 1'b1);
        add_point(5, 5, 1, 1, 1'b0);
        add_point(5, 5, 2, 2, 1'b0);
        add_point(5, 5, 3, 3, 1'b1);
        add_point(-8388608, -8388608, 8388607, -8388608, 1'b0);
        add_point(8388607, -8388608, -8388608, 8388607, 1'b0);
        add_point(-8388608, 8388607, 8388607, 8388607, 1'b0);
        add_point(8388607, 8388607, -8388608, -8388608, 1'b1);
        add_set(3, 2);
        add_set(4, 1);
        drain();

        // more than the maximum number of pairs in one set
        calm = 1'b1;
        for (int i = 0; i < MAX_POINTS_DEF + 6; i++)
            add_point($urandom, $urandom, $urandom, $urandom, i == MAX_POINTS_DEF + 5);
        add_set(5, 0);
        drain();
        calm = 1'b0;

        set_floor(32'd0);
        add_set(3, 2);
        random_sets(130);
        drain();
        set_floor(32'hFFFF_FFFF);
        random_sets(100);
        drain();
        set_floor($urandom);
        random_sets(130);
        drain();
        set_floor(32'd1 << 20);
        random_sets(150);
        drain();

        if (errors == 0 && fit_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
